/* rtl/core/udff_pkg.sv */
// Shared constants, register codes, state type and control structs for the
// unsigned decimal field formatter. No dependencies.

package udff_pkg;

	localparam int MaxField  = 64;
	localparam int FieldW    = 7;
	localparam int PosW      = $clog2(MaxField);
	localparam int ValueW    = 64;
	localparam int NumDigits = 20;
	localparam int DigitIdxW = $clog2(NumDigits);
	localparam int BcdW      = 4 * NumDigits;
	localparam int ConvCntW  = $clog2(ValueW);
	localparam int CharW     = 8;
	localparam int CfgIdxW   = 3;

	localparam logic [CharW-1:0] AsciiZero  = 8'h30;
	localparam logic [CharW-1:0] AsciiSpace = 8'h20;

	typedef enum logic [CfgIdxW-1:0] {
		REG_FIELD_WIDTH     = 3'd0,
		REG_PRECISION       = 3'd1,
		REG_PRECISION_GIVEN = 3'd2,
		REG_ZERO_PAD        = 3'd3,
		REG_PLUS_FLAG       = 3'd4,
		REG_SPACE_FLAG      = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_PLAN,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic conv;
		logic size;
		logic plan;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_last;
		logic more;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/udff_ifs.sv */
// Channel interfaces of the formatter: input value, output character and
// configuration write. Depends on udff_pkg.

interface udff_in_if;
	logic                          valid;
	logic                          ready;
	logic [udff_pkg::ValueW-1:0]   value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface udff_out_if;
	logic                          valid;
	logic                          ready;
	logic [udff_pkg::CharW-1:0]    char_code;
	logic [udff_pkg::PosW-1:0]     position;
	logic                          last;

	modport source (output valid, output char_code, output position, output last, input ready);
	modport sink (input valid, input char_code, input position, input last, output ready);
endinterface

interface udff_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [udff_pkg::CfgIdxW-1:0]  index;
	logic [udff_pkg::FieldW-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/udff_ctrl.sv */
// Sequencing state machine of the formatter: accept, convert, size, plan,
// emit. Depends on udff_pkg.

module udff_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  udff_pkg::sts_t    sts,
	output udff_pkg::cmd_t    cmd
);

	udff_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= udff_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			udff_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = udff_pkg::ST_CONV;
			end
			udff_pkg::ST_CONV: begin
				if (sts.conv_last) state_nxt = udff_pkg::ST_SIZE;
			end
			udff_pkg::ST_SIZE: begin
				state_nxt = udff_pkg::ST_PLAN;
			end
			udff_pkg::ST_PLAN: begin
				state_nxt = udff_pkg::ST_EMIT;
			end
			udff_pkg::ST_EMIT: begin
				// Leave once every character is loaded and the last one is gone.
				if (!sts.more && sts.out_free) state_nxt = udff_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = udff_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			udff_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			udff_pkg::ST_CONV: begin
				cmd.conv = 1'b1;
			end
			udff_pkg::ST_SIZE: begin
				cmd.size = 1'b1;
			end
			udff_pkg::ST_PLAN: begin
				cmd.plan = 1'b1;
			end
			udff_pkg::ST_EMIT: begin
				cmd.emit = sts.more && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/core/udff_dpath.sv */
// Datapath of the formatter: configuration registers, shift-add-3 binary to
// BCD converter, field planning and the character output register.
// Depends on udff_pkg and the channel interfaces.

module udff_dpath (
	input  logic              clk,
	input  logic              arst_n,
	udff_in_if.sink           din,
	udff_out_if.source        dout,
	udff_cfg_if.sink          cfg,
	input  udff_pkg::cmd_t    cmd,
	output udff_pkg::sts_t    sts
);

	localparam logic [udff_pkg::FieldW-1:0] MaxFieldV = udff_pkg::FieldW'(udff_pkg::MaxField);

	// Configuration registers.
	logic [udff_pkg::FieldW-1:0] field_width_q;
	logic [udff_pkg::FieldW-1:0] precision_q;
	logic                        precision_given_q;
	logic                        zero_pad_q;
	logic                        plus_flag_q;
	logic                        space_flag_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q     <= '0;
			precision_q       <= '0;
			precision_given_q <= 1'b0;
			zero_pad_q        <= 1'b0;
			plus_flag_q       <= 1'b0;
			space_flag_q      <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				udff_pkg::REG_FIELD_WIDTH:     field_width_q     <= cfg.data;
				udff_pkg::REG_PRECISION:       precision_q       <= cfg.data;
				udff_pkg::REG_PRECISION_GIVEN: precision_given_q <= cfg.data[0];
				udff_pkg::REG_ZERO_PAD:        zero_pad_q        <= cfg.data[0];
				udff_pkg::REG_PLUS_FLAG:       plus_flag_q       <= cfg.data[0];
				udff_pkg::REG_SPACE_FLAG:      space_flag_q      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	logic [udff_pkg::FieldW-1:0] w_sat;
	logic [udff_pkg::FieldW-1:0] p_sat;

	assign w_sat = (field_width_q > MaxFieldV) ? MaxFieldV : field_width_q;
	assign p_sat = (precision_q > MaxFieldV) ? MaxFieldV : precision_q;

	// Converter registers.
	logic [udff_pkg::ValueW-1:0]            bin_q;
	logic [udff_pkg::NumDigits-1:0][3:0]    bcd_q;
	logic [udff_pkg::ConvCntW-1:0]          conv_cnt_q;
	logic [udff_pkg::NumDigits-1:0][3:0]    bcd_adj;

	always_comb begin
		for (int i = 0; i < udff_pkg::NumDigits; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// Field plan registers.
	logic [udff_pkg::DigitIdxW:0]   ndig_q;
	logic [udff_pkg::FieldW-1:0]    pad_q;
	logic [udff_pkg::FieldW-1:0]    pad_lead_q;
	logic [udff_pkg::FieldW-1:0]    total_q;
	logic [udff_pkg::DigitIdxW-1:0] idx_q;
	logic [udff_pkg::FieldW-1:0]    k_q;

	// Digit count from the highest nonzero BCD digit.
	logic [udff_pkg::DigitIdxW:0] ndig_found;
	logic                         empty_body;

	always_comb begin
		ndig_found = (udff_pkg::DigitIdxW + 1)'(1);
		for (int i = 0; i < udff_pkg::NumDigits; i++) begin
			if (bcd_q[i] != 4'd0) ndig_found = (udff_pkg::DigitIdxW + 1)'(i + 1);
		end
	end

	assign empty_body = precision_given_q && (p_sat == '0) && (bcd_q == '0);

	// Padding and lengths, computed from the digit count.
	logic [udff_pkg::FieldW:0] nd_ext;
	logic [udff_pkg::FieldW:0] p_ext;
	logic [udff_pkg::FieldW:0] w_ext;
	logic [udff_pkg::FieldW:0] lead;
	logic [udff_pkg::FieldW:0] body;
	logic [udff_pkg::FieldW:0] reserve;
	logic [udff_pkg::FieldW:0] pad;
	logic [udff_pkg::FieldW:0] total;
	logic [udff_pkg::FieldW:0] total_cap;

	always_comb begin
		nd_ext    = (udff_pkg::FieldW + 1)'(ndig_q);
		p_ext     = {1'b0, p_sat};
		w_ext     = {1'b0, w_sat};
		lead      = (p_ext > nd_ext) ? p_ext - nd_ext : '0;
		body      = lead + nd_ext;
		reserve   = body + ((plus_flag_q || space_flag_q) ? (udff_pkg::FieldW + 1)'(1) : '0);
		pad       = (w_ext > reserve) ? w_ext - reserve : '0;
		total     = pad + body;
		total_cap = (total > {1'b0, MaxFieldV}) ? {1'b0, MaxFieldV} : total;
	end

	// Character for the current field position.
	logic [udff_pkg::CharW-1:0] next_char;
	logic                       in_digits;

	always_comb begin
		in_digits = 1'b0;
		if (k_q < pad_q) begin
			next_char = zero_pad_q ? udff_pkg::AsciiZero : udff_pkg::AsciiSpace;
		end else if (k_q < pad_lead_q) begin
			next_char = udff_pkg::AsciiZero;
		end else begin
			in_digits = 1'b1;
			next_char = udff_pkg::AsciiZero + {4'd0, bcd_q[idx_q]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q      <= din.value;
			bcd_q      <= '0;
			conv_cnt_q <= '1;
		end else if (cmd.conv) begin
			{bcd_q, bin_q} <= {bcd_adj[udff_pkg::NumDigits-1:0], bin_q} << 1;
			conv_cnt_q     <= conv_cnt_q - udff_pkg::ConvCntW'(1);
		end
		if (cmd.size) begin
			ndig_q <= empty_body ? '0 : ndig_found;
		end
		if (cmd.plan) begin
			pad_q      <= pad[udff_pkg::FieldW-1:0];
			pad_lead_q <= udff_pkg::FieldW'(pad + lead);
			total_q    <= total_cap[udff_pkg::FieldW-1:0];
			idx_q      <= udff_pkg::DigitIdxW'(ndig_q - (udff_pkg::DigitIdxW + 1)'(1));
			k_q        <= '0;
		end else if (cmd.emit) begin
			k_q <= k_q + udff_pkg::FieldW'(1);
			if (in_digits) idx_q <= idx_q - udff_pkg::DigitIdxW'(1);
		end
	end

	// Output register.
	logic                       out_valid_q;
	logic [udff_pkg::CharW-1:0] out_char_q;
	logic [udff_pkg::PosW-1:0]  out_pos_q;
	logic                       out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= next_char;
			out_pos_q  <= k_q[udff_pkg::PosW-1:0];
			out_last_q <= (k_q + udff_pkg::FieldW'(1)) == total_q;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.char_code = out_char_q;
	assign dout.position  = out_pos_q;
	assign dout.last      = out_last_q;

	assign sts.conv_last = (conv_cnt_q == '0);
	assign sts.more      = (k_q != total_q);
	assign sts.out_free  = !out_valid_q || dout.ready;

endmodule

/* rtl/core/unsigned_decimal_field_formatter.sv */
// Top level of the unsigned decimal field formatter: controller plus datapath.
// Depends on udff_pkg, the channel interfaces, udff_ctrl and udff_dpath.
//
//   channel  direction  payload                         transaction
//   din      in         value[63:0]                     valid && ready
//   dout     out        char_code[7:0] position[5:0]    valid && ready
//                       last
//   cfg      in         index[2:0] data[6:0]            valid && ready
//
// An accepted value passes through the shift-add-3 BCD converter, a step
// finding the digit count and one planning the field; characters then
// leave at one per cycle while dout.ready stays high.
// din.ready is high only while no item is in flight; dout stalls hold the
// character register and pause emission. cfg.ready is always high.
// Reset clears the configuration registers to zero and returns to idle.

module unsigned_decimal_field_formatter (
	input  logic          clk,
	input  logic          arst_n,
	udff_in_if.sink       din,
	udff_out_if.source    dout,
	udff_cfg_if.sink      cfg
);

	udff_pkg::cmd_t cmd;
	udff_pkg::sts_t sts;

	udff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	udff_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

/* rtl/core/udff_checker.sv */
// Port-level checks for the formatter, bound to the top level.
// Depends on udff_pkg and unsigned_decimal_field_formatter.

module udff_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [udff_pkg::CharW-1:0]    char_code,
	input  logic [udff_pkg::PosW-1:0]     position,
	input  logic                          last
);

	// A stalled character is held unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code)
			&& $stable(position) && $stable(last))
		else $error("stalled output transaction changed");

	// No new value is taken while a character of the current field waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a character is pending");

	// Conversion comes first, so neither a character nor input ready follows an accept at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid && !in_ready)
		else $error("output or ready right after an input transaction");

	// Within a field, characters follow without gaps at consecutive positions.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid
			&& position == udff_pkg::PosW'($past(position) + udff_pkg::PosW'(1)))
		else $error("field characters not consecutive");

endmodule

bind unsigned_decimal_field_formatter udff_checker u_udff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.char_code (dout.char_code),
	.position  (dout.position),
	.last      (dout.last)
);
